### src/isp_pkg.sv
// Shared types and constants of the three-impulse input shaper.
// No dependencies; every other file imports this package.
package isp_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 16;
   localparam int TAP_W       = 9;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Signed product of an unsigned weight and a signed sample, and the
   // sum of three such products.
   localparam int PROD_W  = COEF_W + SAMPLE_W + 1;
   localparam int SUM_W   = PROD_W + 2;
   localparam int FRAC_W  = 15;

   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

   localparam logic [TAP_W-1:0]  TAP_DELAY_RST   = '0;
   localparam logic [COEF_W-1:0] COEF_FIRST_RST  = 16'd8192;
   localparam logic [COEF_W-1:0] COEF_MIDDLE_RST = 16'd16384;
   localparam logic [COEF_W-1:0] COEF_LAST_RST   = 16'd8192;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE,
      CSR_TAP_DELAY,
      CSR_COEF_FIRST,
      CSR_COEF_MIDDLE,
      CSR_COEF_LAST
   } csr_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] first;
      logic [COEF_W-1:0] middle;
      logic [COEF_W-1:0] last;
   } coef_set_type;

   // Per-transfer control handed from the address side to the datapath.
   typedef struct packed {
      logic bypass;
      logic fwd_mid;
      logic fwd_last;
   } tap_ctl_type;

endpackage

### src/three_impulse_input_shaper_core.sv
// Three-impulse input shaper, top level. Depends on isp_pkg, isp_store, isp_addr, isp_dp.
// A result passes the s1, s2, s3 and output registers after its input transfer.
// One sample per cycle unless stalled, set by the four-stage pipeline and 1W2R store.
// Reset: clears the index and valid flags, presets the configuration, then sweeps zeros
// through the whole store with req_ready low; configuration writes are taken throughout.
module three_impulse_input_shaper_core
   import isp_pkg::*;
#(
   parameter int STORE_DEPTH = 1024,
   parameter int RING_MARGIN = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_W-1:0]    req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_W-1:0]    rsp_shaped_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int AW = $clog2(STORE_DEPTH);

   // Configuration registers.
   logic             enable_ff, enable_in;
   logic [TAP_W-1:0] tap_delay_ff, tap_delay_in;
   coef_set_type     coef_ff, coef_in;

   logic                req_xfer;
   logic                dp_ready;
   logic                clear_busy;
   logic                shape_xfer;
   logic [AW-1:0]       wr_addr, mid_addr, last_addr;
   logic [SAMPLE_W-1:0] tap_mid, tap_last;
   tap_ctl_type         tap_ctl;

   // The register port never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      enable_in    = enable_ff;
      tap_delay_in = tap_delay_ff;
      coef_in      = coef_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE:      enable_in     = csr_data[0];
            CSR_TAP_DELAY:   tap_delay_in  = csr_data[TAP_W-1:0];
            CSR_COEF_FIRST:  coef_in.first  = csr_data;
            CSR_COEF_MIDDLE: coef_in.middle = csr_data;
            CSR_COEF_LAST:   coef_in.last   = csr_data;
            default: ; // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         tap_delay_ff   <= TAP_DELAY_RST;
         coef_ff.first  <= COEF_FIRST_RST;
         coef_ff.middle <= COEF_MIDDLE_RST;
         coef_ff.last   <= COEF_LAST_RST;
      end else begin
         enable_ff    <= enable_in;
         tap_delay_ff <= tap_delay_in;
         coef_ff      <= coef_in;
      end
   end

   // Hold off input transfers while the clearing sweep runs.
   assign req_ready  = dp_ready && !clear_busy;
   assign req_xfer   = req_valid && req_ready;
   // Only shaped samples touch the store and the index; pass-through leaves them alone.
   assign shape_xfer = req_xfer && enable_ff;

   // A tap that lands on the entry being written this cycle must take the
   // incoming sample: the registered read still returns the old contents.
   // This happens only with a zero tap delay.
   always_comb begin
      tap_ctl.bypass   = !enable_ff;
      tap_ctl.fwd_mid  = (mid_addr == wr_addr);
      tap_ctl.fwd_last = (last_addr == wr_addr);
   end

   isp_addr #(
      .STORE_DEPTH (STORE_DEPTH),
      .RING_MARGIN (RING_MARGIN)
   ) u_addr (
      .clock     (clock),
      .reset     (reset),
      .advance   (shape_xfer),
      .tap_delay (tap_delay_ff),
      .wr_addr   (wr_addr),
      .mid_addr  (mid_addr),
      .last_addr (last_addr)
   );

   // Writes land at their own transfer's edge, before any later sample's reads, so
   // back-to-back samples see each other without further forwarding.
   isp_store #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (shape_xfer),
      .wr_addr    (wr_addr),
      .wr_data    (req_sample_in),
      .rd_en      (req_xfer),
      .rd_addr_a  (mid_addr),
      .rd_addr_b  (last_addr),
      .rd_data_a  (tap_mid),
      .rd_data_b  (tap_last),
      .clear_busy (clear_busy)
   );

   isp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_xfer),
      .in_ctl     (tap_ctl),
      .in_sample  (req_sample_in),
      .tap_mid    (tap_mid),
      .tap_last   (tap_last),
      .coefs      (coef_ff),
      .in_ready   (dp_ready),
      .out_ready  (rsp_ready),
      .out_valid  (rsp_valid),
      .out_sample (rsp_shaped_out)
   );

endmodule

### src/isp_store.sv
// Sample ring memory: one write port, two registered read ports, clearing sweep.
// Depends on isp_pkg.
module isp_store
   import isp_pkg::*;
#(
   parameter int STORE_DEPTH = 1024,
   localparam int AW = $clog2(STORE_DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   output logic [SAMPLE_W-1:0] rd_data_a,
   output logic [SAMPLE_W-1:0] rd_data_b,
   output logic                clear_busy
);

   logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_a_ff, rd_data_b_ff;
   logic                clr_busy_ff, clr_busy_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [SAMPLE_W-1:0] mem_wdata;

   // Sweep zeros through every entry after reset.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(STORE_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_comb begin
      mem_we    = clr_busy_ff | wr_en;
      mem_waddr = clr_busy_ff ? clr_addr_ff : wr_addr;
      mem_wdata = clr_busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a  = rd_data_a_ff;
   assign rd_data_b  = rd_data_b_ff;
   assign clear_busy = clr_busy_ff;

endmodule

### src/isp_addr.sv
// Ring index register and tap address generation.
// Depends on isp_pkg.
module isp_addr
   import isp_pkg::*;
#(
   parameter int STORE_DEPTH = 1024,
   parameter int RING_MARGIN = 10,
   localparam int AW = $clog2(STORE_DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [TAP_W-1:0] tap_delay,
   output logic [AW-1:0]    wr_addr,
   output logic [AW-1:0]    mid_addr,
   output logic [AW-1:0]    last_addr
);

   localparam int CW      = (AW + 1 > TAP_W) ? AW + 1 : TAP_W;
   localparam int MAX_TAP = (STORE_DEPTH - RING_MARGIN) / 2;

   logic [AW-1:0] write_index_ff, write_index_in;
   logic [CW-1:0] tap_ext, td, back2, len, idx, idx_inc, mid, last;

   always_comb begin
      tap_ext = CW'(tap_delay);
      // clamp so the active length fits the store
      td      = (tap_ext > CW'(MAX_TAP)) ? CW'(MAX_TAP) : tap_ext;
      back2   = {td[CW-2:0], 1'b0};
      len     = back2 + CW'(RING_MARGIN);
      idx     = CW'(write_index_ff);
      mid     = (idx >= td)    ? idx - td    : idx + len - td;
      last    = (idx >= back2) ? idx - back2 : idx + len - back2;
      idx_inc = idx + CW'(1);
      write_index_in = write_index_ff;
      if (advance) begin
         write_index_in = (idx_inc >= len) ? '0 : idx_inc[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff <= '0;
      end else begin
         write_index_ff <= write_index_in;
      end
   end

   assign wr_addr   = write_index_ff;
   assign mid_addr  = mid[AW-1:0];
   assign last_addr = last[AW-1:0];

endmodule

### src/isp_dp.sv
// Weighting pipeline: tap select, three multiplies, sum, shift and saturate, or pass-through.
// Depends on isp_pkg.
module isp_dp
   import isp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  tap_ctl_type                in_ctl,
   input  logic signed [SAMPLE_W-1:0] in_sample,
   input  logic [SAMPLE_W-1:0]        tap_mid,
   input  logic [SAMPLE_W-1:0]        tap_last,
   input  coef_set_type               coefs,
   output logic                       in_ready,
   input  logic                       out_ready,
   output logic                       out_valid,
   output logic signed [SAMPLE_W-1:0] out_sample
);

   logic                       s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic                       ready1, ready2, ready3;
   tap_ctl_type                s1_ctl_ff;
   logic signed [SAMPLE_W-1:0] s1_x_ff, s2_x_ff, s3_x_ff;
   logic                       s2_byp_ff, s3_byp_ff;
   logic signed [SAMPLE_W-1:0] mid_val, last_val;
   logic signed [COEF_W:0]     c_first, c_mid, c_last;
   logic signed [PROD_W-1:0]   p_first_in, p_mid_in, p_last_in;
   logic signed [PROD_W-1:0]   p_first_ff, p_mid_ff, p_last_ff;
   logic signed [SUM_W-1:0]    sum_in, sum_ff;
   logic signed [SAMPLE_W-1:0] sat_val, out_in, out_ff;

   // Each stage moves when the one after it has room.
   always_comb begin
      ready3   = !out_v_ff || out_ready;
      ready2   = !s3_v_ff || ready3;
      ready1   = !s2_v_ff || ready2;
      in_ready = !s1_v_ff || ready1;
   end

   always_comb begin
      mid_val  = s1_ctl_ff.fwd_mid  ? s1_x_ff : $signed(tap_mid);
      last_val = s1_ctl_ff.fwd_last ? s1_x_ff : $signed(tap_last);
      c_first  = $signed({1'b0, coefs.first});
      c_mid    = $signed({1'b0, coefs.middle});
      c_last   = $signed({1'b0, coefs.last});
      p_first_in = c_first * s1_x_ff;
      p_mid_in   = c_mid * mid_val;
      p_last_in  = c_last * last_val;
      sum_in = SUM_W'(p_first_ff) + SUM_W'(p_mid_ff) + SUM_W'(p_last_ff);
      // floor shift by the fraction width, then clip to the sample range
      if (&sum_ff[SUM_W-1:FRAC_W+SAMPLE_W-1] || ~|sum_ff[SUM_W-1:FRAC_W+SAMPLE_W-1]) begin
         sat_val = $signed(sum_ff[FRAC_W+SAMPLE_W-1:FRAC_W]);
      end else begin
         sat_val = sum_ff[SUM_W-1] ? SAT_MIN : SAT_MAX;
      end
      out_in = s3_byp_ff ? s3_x_ff : sat_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            s1_v_ff <= in_valid;
         end
         if (ready1) begin
            s2_v_ff <= s1_v_ff;
         end
         if (ready2) begin
            s3_v_ff <= s2_v_ff;
         end
         if (ready3) begin
            out_v_ff <= s3_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s1_ctl_ff <= in_ctl;
         s1_x_ff   <= in_sample;
      end
      if (ready1 && s1_v_ff) begin
         s2_byp_ff  <= s1_ctl_ff.bypass;
         s2_x_ff    <= s1_x_ff;
         p_first_ff <= p_first_in;
         p_mid_ff   <= p_mid_in;
         p_last_ff  <= p_last_in;
      end
      if (ready2 && s2_v_ff) begin
         s3_byp_ff <= s2_byp_ff;
         s3_x_ff   <= s2_x_ff;
         sum_ff    <= sum_in;
      end
      if (ready3 && s3_v_ff) begin
         out_ff <= out_in;
      end
   end

   assign out_valid  = out_v_ff;
   assign out_sample = out_ff;

endmodule

### src/isp_checker.sv
// Port-level checks for the three-impulse input shaper core, bound to the top level.
// Depends on isp_pkg and three_impulse_input_shaper_core.
module isp_checker
   import isp_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_shaped_out
);

   // Reset empties the pipeline and starts the clearing sweep.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("input open or result shown right after reset");

   // With the result side always taking, a transfer comes out through the pipeline registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("result missing after a free-flowing transfer");

   // A waiting result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_shaped_out))
      else $error("stalled result dropped or changed");

endmodule

bind three_impulse_input_shaper_core isp_checker u_checker (.*);
